// ===== src/euq_pkg.sv =====
package euq_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int NSTEP        = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    localparam int AW  = 16;   // angle and component width
    localparam int ZW  = 25;   // residual angle, degrees times 65536
    localparam int XW  = 33;   // cordic x and y, q30 with headroom
    localparam int SCW = 18;   // sine and cosine, q16
    localparam int PW  = 2 * SCW;
    localparam int TW  = 3 * SCW;
    localparam int SW  = TW + 1;
    localparam int RW  = SW - 34;

    // pipeline stages: init, iterations, round, pair, triple, output
    localparam int LAT = NSTEP + 5;

    localparam logic signed [AW-1:0] ANGLE_LIMIT = 16'sd23040;
    localparam logic signed [XW-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [XW-1:0] RND_Q30     = 33'sd8192;
    localparam logic signed [SW-1:0] RND_Q48     = 55'sd8589934592;
    localparam logic signed [RW-1:0] UNIT_POS    = 21'sd16384;
    localparam logic signed [RW-1:0] UNIT_NEG    = -21'sd16384;

    typedef logic signed [ZW-1:0]  z_t;
    typedef logic signed [XW-1:0]  xy_t;
    typedef logic signed [SCW-1:0] sc_t;
    typedef logic signed [PW-1:0]  pair_t;
    typedef logic signed [TW-1:0]  trip_t;

    // atan(2^-i) in degrees times 65536
    function automatic z_t atan_q16(input int idx);
        z_t r;
        r = '0;
        unique case (idx)
            0:  r = 25'sd2949120;
            1:  r = 25'sd1740967;
            2:  r = 25'sd919879;
            3:  r = 25'sd466945;
            4:  r = 25'sd234379;
            5:  r = 25'sd117304;
            6:  r = 25'sd58666;
            7:  r = 25'sd29335;
            8:  r = 25'sd14668;
            9:  r = 25'sd7334;
            10: r = 25'sd3667;
            11: r = 25'sd1833;
            12: r = 25'sd917;
            13: r = 25'sd458;
            14: r = 25'sd229;
            15: r = 25'sd115;
            16: r = 25'sd57;
            17: r = 25'sd29;
            18: r = 25'sd14;
            19: r = 25'sd7;
            20: r = 25'sd4;
            21: r = 25'sd2;
            22: r = 25'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/euler_to_quaternion_top.sv =====
// channel | signals                                   | direction
// input   | in_valid, in_ready, roll/pitch/yaw_deg    | upstream -> block
// output  | out_valid, out_ready, quat_w/x/y/z        | block -> downstream
//
// one angle triple enters every cycle while in_ready is high; the stages are
// load, one cordic iteration per stage, round, two product stages and sum
// reset clears only the stage valid bits, payload registers are not reset
// a held result freezes the whole pipeline; in_ready drops only then
module euler_to_quaternion_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [euq_pkg::AW-1:0]      roll_deg,
    input  logic signed [euq_pkg::AW-1:0]      pitch_deg,
    input  logic signed [euq_pkg::AW-1:0]      yaw_deg,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [euq_pkg::AW-1:0]      quat_w,
    output logic signed [euq_pkg::AW-1:0]      quat_x,
    output logic signed [euq_pkg::AW-1:0]      quat_y,
    output logic signed [euq_pkg::AW-1:0]      quat_z
);
    import euq_pkg::*;

    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    // axis 0 roll, 1 pitch, 2 yaw
    z_t  z_reg [3][NSTEP+1];
    xy_t x_reg [3][NSTEP+1];
    xy_t y_reg [3][NSTEP+1];
    sc_t s_reg [3];
    sc_t c_reg [3];
    logic signed [AW-1:0] ang [3];

    pair_t c1c2_reg, s1s2_reg, c1s2_reg, s1c2_reg;
    sc_t   s3_reg, c3_reg;
    trip_t tw1_reg, tw2_reg, tx1_reg, tx2_reg;
    trip_t ty1_reg, ty2_reg, tz1_reg, tz2_reg;
    logic signed [AW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;

    // whole pipe moves unless a result is held
    assign adv      = !vld_reg[LAT-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign ang[0] = roll_deg;
    assign ang[1] = pitch_deg;
    assign ang[2] = yaw_deg;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        logic signed [AW-1:0] clamp;

        // clamp to plus or minus 180 and halve into degrees times 65536
        always_comb
        begin
            priority if (ang[a] > ANGLE_LIMIT)
                clamp = ANGLE_LIMIT;
            else if (ang[a] < -ANGLE_LIMIT)
                clamp = -ANGLE_LIMIT;
            else
                clamp = ang[a];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                z_reg[a][0] <= z_t'({{(ZW-AW-8){clamp[AW-1]}}, clamp, 8'd0});
                x_reg[a][0] <= GAIN_Q30;
                y_reg[a][0] <= '0;
            end
        end

        // one cordic rotation per stage
        for (genvar i = 0; i < NSTEP; i++)
        begin : g_step
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (!z_reg[a][i][ZW-1])
                    begin
                        x_reg[a][i+1] <= x_reg[a][i] - (y_reg[a][i] >>> i);
                        y_reg[a][i+1] <= y_reg[a][i] + (x_reg[a][i] >>> i);
                        z_reg[a][i+1] <= z_reg[a][i] - atan_q16(i);
                    end
                    else
                    begin
                        x_reg[a][i+1] <= x_reg[a][i] + (y_reg[a][i] >>> i);
                        y_reg[a][i+1] <= y_reg[a][i] - (x_reg[a][i] >>> i);
                        z_reg[a][i+1] <= z_reg[a][i] + atan_q16(i);
                    end
                end
            end
        end

        // round q30 to q16
        xy_t xr, yr;
        assign xr = x_reg[a][NSTEP] + RND_Q30;
        assign yr = y_reg[a][NSTEP] + RND_Q30;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                c_reg[a] <= xr[SCW+13:14];
                s_reg[a] <= yr[SCW+13:14];
            end
        end
    end

    // yaw and pitch pair products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1c2_reg <= c_reg[2] * c_reg[1];
            s1s2_reg <= s_reg[2] * s_reg[1];
            c1s2_reg <= c_reg[2] * s_reg[1];
            s1c2_reg <= s_reg[2] * c_reg[1];
            c3_reg   <= c_reg[0];
            s3_reg   <= s_reg[0];
        end
    end

    // triple products with roll
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tw1_reg <= c1c2_reg * c3_reg;
            tw2_reg <= s1s2_reg * s3_reg;
            tx1_reg <= c1c2_reg * s3_reg;
            tx2_reg <= s1s2_reg * c3_reg;
            ty1_reg <= c1s2_reg * c3_reg;
            ty2_reg <= s1c2_reg * s3_reg;
            tz1_reg <= s1c2_reg * c3_reg;
            tz2_reg <= c1s2_reg * s3_reg;
        end
    end

    // sum, round to q14 and saturate
    function automatic logic signed [AW-1:0] to_q14(input trip_t p, input trip_t q,
                                                    input logic neg);
        logic signed [SW-1:0] sum;
        logic signed [RW-1:0] r;
        sum = neg ? (SW'(p) - SW'(q)) : (SW'(p) + SW'(q));
        sum = sum + RND_Q48;
        r   = sum[SW-1:34];
        priority if (r > UNIT_POS)
            r = UNIT_POS;
        else if (r < UNIT_NEG)
            r = UNIT_NEG;
        return r[AW-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qw_reg <= to_q14(tw1_reg, tw2_reg, 1'b0);
            qx_reg <= to_q14(tx1_reg, tx2_reg, 1'b1);
            qy_reg <= to_q14(ty1_reg, ty2_reg, 1'b0);
            qz_reg <= to_q14(tz1_reg, tz2_reg, 1'b1);
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign quat_w    = qw_reg;
    assign quat_x    = qx_reg;
    assign quat_y    = qy_reg;
    assign quat_z    = qz_reg;

endmodule

// ===== src/euq_checker.sv =====
module euq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [euq_pkg::AW-1:0] quat_w,
    input logic signed [euq_pkg::AW-1:0] quat_x,
    input logic signed [euq_pkg::AW-1:0] quat_y,
    input logic signed [euq_pkg::AW-1:0] quat_z
);
    import euq_pkg::*;

    // a held transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
            && $stable(quat_y) && $stable(quat_z))
        else $error("held result changed");

    // empty output never blocks the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a taken result frees the pipe in the same cycle
    a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // components stay within unit magnitude
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= 16384 && quat_w >= -16384 && quat_x <= 16384
            && quat_x >= -16384 && quat_y <= 16384 && quat_y >= -16384
            && quat_z <= 16384 && quat_z >= -16384)
        else $error("component beyond unit");

endmodule

bind euler_to_quaternion_top euq_checker u_euq_checker (.*);
